[hdl/tbw_pkg.sv]
// shared widths and register indexes for the barycentric warp
`default_nettype none
package tbw_pkg;
  localparam int unsigned CoordWidth = 16;
  localparam int unsigned NumRegs    = 6;
  localparam int unsigned AddrWidth  = 5;

  typedef enum logic [2:0] {
    REG_SRC_V1_X = 3'd0,
    REG_SRC_V1_Y = 3'd1,
    REG_SRC_V2_X = 3'd2,
    REG_SRC_V2_Y = 3'd3,
    REG_SRC_V3_X = 3'd4,
    REG_SRC_V3_Y = 3'd5
  } reg_idx_e;
endpackage
`default_nettype wire

[hdl/triangle_barycentric_point_warp.sv]
// top level: config registers, weight and numerator pipeline, two dividers
// throughput: one item per cycle while the output is not stalled; the whole pipeline advances together
// the pipe holds when the output register is full and not taken
// reset clears all valid bits and source triangle registers to zero
// divider depth is set by the numerator width, one quotient bit per stage
`default_nettype none
module triangle_barycentric_point_warp #(
  parameter int unsigned COORD_WIDTH = tbw_pkg::CoordWidth
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // point_x, point_y, dst_v1_x, dst_v1_y, dst_v2_x, dst_v2_y, dst_v3_x, dst_v3_y
  input  wire logic [8*COORD_WIDTH-1:0]     s_axis_tdata,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  // out_x, out_y
  output logic [((2*COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  // degenerate
  output logic                              m_axis_tuser,
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [tbw_pkg::AddrWidth-1:0] paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import tbw_pkg::*;

  localparam int unsigned W    = COORD_WIDTH;
  localparam int unsigned DW   = W + 1;
  localparam int unsigned PW   = 2*DW;
  localparam int unsigned AW   = PW + 2;
  localparam int unsigned NW   = AW + W + 2;
  localparam int unsigned NMW  = NW - 1;
  localparam int unsigned DMW  = AW;
  localparam int unsigned DivLat = NMW + 1;
  localparam int unsigned Pre  = 5;
  localparam int unsigned Lat  = Pre + DivLat;
  localparam int unsigned OutW = ((2*W+7)/8)*8;

  // configuration registers
  logic signed [W-1:0] src_q [NumRegs];
  logic [2:0]          cfg_idx;
  logic                cfg_hit;
  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_hit = paddr[1:0] == 2'b00 && cfg_idx < 3'(NumRegs);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) src_q[i] <= '0;
    end else if (psel && penable && pwrite && cfg_hit) begin
      src_q[cfg_idx] <= W'(pwdata);
    end
  end

  always_comb begin
    prdata = '0;
    if (cfg_hit) prdata = 32'(signed'(src_q[cfg_idx]));
  end

  // pipeline advance and valid chain
  logic           adv;
  logic [Lat-1:0] vld_q;
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (adv) vld_q <= {vld_q[Lat-2:0], s_axis_tvalid};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m_axis_tvalid <= 1'b0;
    else if (adv) m_axis_tvalid <= vld_q[Lat-1];
  end

  // stage 1: differences
  logic signed [W-1:0] px, py;
  logic signed [W-1:0] t_i [6];
  assign px = s_axis_tdata[W-1:0];
  assign py = s_axis_tdata[2*W-1:W];
  for (genvar k = 0; k < 6; k++) begin : g_t
    assign t_i[k] = s_axis_tdata[(k+3)*W-1:(k+2)*W];
  end

  logic signed [DW-1:0] dx_q [3], dy_q [3];
  logic signed [DW-1:0] sx_q [2], sy_q [2];
  logic signed [W-1:0]  t1_q [6];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        dx_q[k] <= DW'(src_q[2*k]) - DW'(px);
        dy_q[k] <= DW'(src_q[2*k+1]) - DW'(py);
      end
      sx_q[0] <= DW'(src_q[REG_SRC_V2_X]) - DW'(src_q[REG_SRC_V1_X]);
      sy_q[0] <= DW'(src_q[REG_SRC_V2_Y]) - DW'(src_q[REG_SRC_V1_Y]);
      sx_q[1] <= DW'(src_q[REG_SRC_V3_X]) - DW'(src_q[REG_SRC_V1_X]);
      sy_q[1] <= DW'(src_q[REG_SRC_V3_Y]) - DW'(src_q[REG_SRC_V1_Y]);
      t1_q    <= t_i;
    end
  end

  // stage 2: products
  logic signed [PW-1:0] p_q [6];
  logic signed [W-1:0]  t2_q [6];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_q[0] <= PW'(sx_q[0]) * PW'(sy_q[1]);
      p_q[1] <= PW'(sx_q[1]) * PW'(sy_q[0]);
      p_q[2] <= PW'(dx_q[1]) * PW'(dy_q[2]);
      p_q[3] <= PW'(dx_q[2]) * PW'(dy_q[1]);
      p_q[4] <= PW'(dx_q[2]) * PW'(dy_q[0]);
      p_q[5] <= PW'(dx_q[0]) * PW'(dy_q[2]);
      t2_q   <= t1_q;
    end
  end

  // stage 3: determinant and weight numerators
  logic signed [AW-1:0] d3_q, a3_q, b3_q;
  logic signed [W-1:0]  t3_q [6];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      d3_q <= AW'(p_q[0]) - AW'(p_q[1]);
      a3_q <= AW'(p_q[2]) - AW'(p_q[3]);
      b3_q <= AW'(p_q[4]) - AW'(p_q[5]);
      t3_q <= t2_q;
    end
  end

  // stage 4: gamma numerator and weighted products
  logic signed [NW-1:0] m_q [6];
  logic signed [AW-1:0] d4_q;
  logic signed [AW-1:0] c4;
  assign c4 = d3_q - a3_q - b3_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int e = 0; e < 2; e++) begin
        m_q[3*e]   <= NW'(a3_q) * NW'(t3_q[e]);
        m_q[3*e+1] <= NW'(b3_q) * NW'(t3_q[e+2]);
        m_q[3*e+2] <= NW'(c4)   * NW'(t3_q[e+4]);
      end
      d4_q <= d3_q;
    end
  end

  // stage 5: sums, signs and magnitudes
  logic signed [NW-1:0] n_sum [2];
  logic [NMW-1:0]       nm_q [2];
  logic [DMW-1:0]       dm_q;
  logic                 ng_q [2];
  logic                 z_q;
  for (genvar e = 0; e < 2; e++) begin : g_sum
    assign n_sum[e] = m_q[3*e] + m_q[3*e+1] + m_q[3*e+2];
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int e = 0; e < 2; e++) begin
        nm_q[e] <= n_sum[e][NW-1] ? NMW'(-n_sum[e]) : NMW'(n_sum[e]);
        ng_q[e] <= n_sum[e][NW-1] ^ d4_q[AW-1];
      end
      dm_q <= d4_q[AW-1] ? DMW'(-d4_q) : DMW'(d4_q);
      z_q  <= d4_q == '0;
    end
  end

  // degenerate flag delayed to match dividers
  logic [DivLat-1:0] zd_q;
  always_ff @(posedge clk_i) begin
    if (adv) zd_q <= {zd_q[DivLat-2:0], z_q};
  end

  logic signed [W-1:0] qx, qy;
  tbw_div #(.NumWidth(NMW), .DenWidth(DMW), .CoordWidth(W)) u_div_x (
    .clk_i(clk_i), .en_i(adv), .num_mag_i(nm_q[0]), .den_mag_i(dm_q),
    .neg_i(ng_q[0]), .zero_i(z_q), .quot_o(qx)
  );
  tbw_div #(.NumWidth(NMW), .DenWidth(DMW), .CoordWidth(W)) u_div_y (
    .clk_i(clk_i), .en_i(adv), .num_mag_i(nm_q[1]), .den_mag_i(dm_q),
    .neg_i(ng_q[1]), .zero_i(z_q), .quot_o(qy)
  );

  // output register
  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_axis_tdata <= OutW'({qy, qx});
      m_axis_tuser <= zd_q[DivLat-1];
    end
  end

  // a stalled result stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && m_axis_tvalid)
    else $error("result changed while stalled");
  // degenerate results carry zero coordinates
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("degenerate result not zero");
  // input is held off exactly when the output is blocked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("ready mismatch");
endmodule
`default_nettype wire

[hdl/tbw_div.sv]
// pipelined restoring divider with round-to-nearest (ties away from zero) and saturation
`default_nettype none
module tbw_div #(
  parameter int unsigned NumWidth   = 68,
  parameter int unsigned DenWidth   = 36,
  parameter int unsigned CoordWidth = tbw_pkg::CoordWidth
) (
  input  wire logic                         clk_i,
  input  wire logic                         en_i,
  input  wire logic [NumWidth-1:0]          num_mag_i,
  input  wire logic [DenWidth-1:0]          den_mag_i,
  input  wire logic                         neg_i,
  input  wire logic                         zero_i,
  output logic signed [CoordWidth-1:0]      quot_o
);
  import tbw_pkg::*;

  localparam int unsigned Steps = NumWidth;
  localparam int unsigned RemW  = DenWidth + 1;
  localparam int unsigned QmaxW = CoordWidth + 1;

  // one quotient bit per stage; quotient is kept clipped to QmaxW bits plus overflow flag
  logic [RemW-1:0]     rem_q  [Steps];
  logic [NumWidth-1:0] num_q  [Steps];
  logic [DenWidth-1:0] den_q  [Steps];
  logic [QmaxW-1:0]    quo_q  [Steps];
  logic                ovf_q  [Steps];
  logic                neg_q  [Steps];
  logic                zero_q [Steps];

  for (genvar s = 0; s < Steps; s++) begin : g_step
    logic [RemW-1:0]     rem_in;
    logic [NumWidth-1:0] num_in;
    logic [DenWidth-1:0] den_in;
    logic [QmaxW-1:0]    quo_in;
    logic                ovf_in;
    logic                neg_in;
    logic                zero_in;
    logic [RemW:0]       trial;
    logic                take;
    logic [RemW-1:0]     rem_d;
    // first stage starts from the inputs, later ones from the previous stage
    if (s == 0) begin : g_head
      assign rem_in  = '0;
      assign num_in  = num_mag_i;
      assign den_in  = den_mag_i;
      assign quo_in  = '0;
      assign ovf_in  = 1'b0;
      assign neg_in  = neg_i;
      assign zero_in = zero_i;
    end else begin : g_tail
      assign rem_in  = rem_q[s-1];
      assign num_in  = num_q[s-1];
      assign den_in  = den_q[s-1];
      assign quo_in  = quo_q[s-1];
      assign ovf_in  = ovf_q[s-1];
      assign neg_in  = neg_q[s-1];
      assign zero_in = zero_q[s-1];
    end
    always_comb begin
      trial = {rem_in, num_in[NumWidth-1]};
      take  = trial >= {2'b00, den_in};
      rem_d = take ? RemW'(trial - {2'b00, den_in}) : RemW'(trial);
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= rem_d;
        num_q[s]  <= {num_in[NumWidth-2:0], 1'b0};
        den_q[s]  <= den_in;
        quo_q[s]  <= {quo_in[QmaxW-2:0], take};
        ovf_q[s]  <= ovf_in | quo_in[QmaxW-1];
        neg_q[s]  <= neg_in;
        zero_q[s] <= zero_in;
      end
    end
  end

  // rounding and clamp
  logic [DenWidth:0] twice_rem;
  logic              rnd_up;
  logic [QmaxW:0]    mag;
  logic              big;
  logic [QmaxW:0]    pos_max;
  logic [QmaxW:0]    neg_max;
  logic signed [CoordWidth-1:0] res_d;

  always_comb begin
    twice_rem = {rem_q[Steps-1][DenWidth-1:0], 1'b0};
    rnd_up    = twice_rem >= {1'b0, den_q[Steps-1]};
    mag       = {1'b0, quo_q[Steps-1]} + (QmaxW+1)'(rnd_up);
    pos_max   = {3'b000, {(CoordWidth-1){1'b1}}};
    neg_max   = {3'b001, {(CoordWidth-1){1'b0}}};
    big       = ovf_q[Steps-1];
    if (zero_q[Steps-1]) begin
      res_d = '0;
    end else if (neg_q[Steps-1]) begin
      res_d = (big || mag > neg_max) ? CoordWidth'(neg_max)
                                     : CoordWidth'(-mag);
    end else begin
      res_d = (big || mag > pos_max) ? CoordWidth'(pos_max) : CoordWidth'(mag);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quot_o <= res_d;
    end
  end
endmodule
`default_nettype wire

[verif/tb_triangle_barycentric_point_warp.sv]
// self-checking testbench for the triangle barycentric point warp block
`timescale 1ns / 100ps
`default_nettype none
module tb_triangle_barycentric_point_warp;
  import tbw_pkg::*;

  localparam int unsigned CW = CoordWidth;
  localparam int unsigned Latency = 3 * CW + 12;
  localparam int unsigned NumRandom = 1230;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    coord_t dv3y, dv3x, dv2y, dv2x, dv1y, dv1x, py, px;
  } warp_in_t;

  typedef struct packed {
    coord_t oy;
    coord_t ox;
    logic   degen;
  } warp_out_t;

  // one directed row: optional typed-in result
  typedef struct {
    warp_in_t  pt;
    logic      fixed;
    warp_out_t res;
  } dir_row_t;

  logic clk_i, rst_ni;
  logic [8*CW-1:0] s_axis_tdata;
  logic s_axis_tvalid, s_axis_tready;
  logic [((2*CW+7)/8)*8-1:0] m_axis_tdata;
  logic m_axis_tuser, m_axis_tvalid, m_axis_tready;
  logic psel, penable, pwrite;
  logic [AddrWidth-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  triangle_barycentric_point_warp u_top (
    .clk_i, .rst_ni, .s_axis_tdata, .s_axis_tvalid, .s_axis_tready,
    .m_axis_tdata, .m_axis_tuser, .m_axis_tvalid, .m_axis_tready,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // source triangle copy kept by the testbench
  coord_t src_tri[NumRegs];
  warp_out_t warp_q[$];
  int unsigned n_errors, n_sent, n_got, n_degen, n_sat;
  bit hold_off_req;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("FAILURE");
    $finish;
  end

  // round n/d to nearest, ties away from zero, then saturate
  function automatic coord_t div_sat(logic signed [127:0] n, logic signed [127:0] d);
    logic [127:0] nm, dm, q, r;
    logic signed [127:0] sq;
    bit neg;
    neg = (n < 0) != (d < 0);
    nm = (n < 0) ? -n : n;
    dm = (d < 0) ? -d : d;
    q = nm / dm;
    r = nm % dm;
    if (r >= dm - r) q = q + 1;
    sq = neg ? -$signed(q) : $signed(q);
    if (sq > (128'sd1 <<< (CW - 1)) - 1) sq = (128'sd1 <<< (CW - 1)) - 1;
    if (sq < -(128'sd1 <<< (CW - 1))) sq = -(128'sd1 <<< (CW - 1));
    return coord_t'(sq);
  endfunction

  // barycentric weights over the source triangle, blend of the target vertices
  function automatic warp_out_t warp_point(warp_in_t p);
    logic signed [127:0] x1, y1, x2, y2, x3, y3, px, py, d, a, b, c;
    warp_out_t o;
    x1 = src_tri[REG_SRC_V1_X]; y1 = src_tri[REG_SRC_V1_Y];
    x2 = src_tri[REG_SRC_V2_X]; y2 = src_tri[REG_SRC_V2_Y];
    x3 = src_tri[REG_SRC_V3_X]; y3 = src_tri[REG_SRC_V3_Y];
    px = p.px; py = p.py;
    d = (x2 - x1) * (y3 - y1) - (x3 - x1) * (y2 - y1);
    if (d == 0) begin
      o = '{ox: '0, oy: '0, degen: 1'b1};
      return o;
    end
    a = (x2 - px) * (y3 - py) - (x3 - px) * (y2 - py);
    b = (x3 - px) * (y1 - py) - (x1 - px) * (y3 - py);
    c = d - a - b;
    o.ox = div_sat(a * 128'(p.dv1x) + b * 128'(p.dv2x) + c * 128'(p.dv3x), d);
    o.oy = div_sat(a * 128'(p.dv1y) + b * 128'(p.dv2y) + c * 128'(p.dv3y), d);
    o.degen = 1'b0;
    return o;
  endfunction

  task automatic write_reg(reg_idx_e idx, coord_t val);
    @(negedge clk_i);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
    paddr = AddrWidth'(4 * int'(idx)); pwdata = 32'($signed(val));
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    src_tri[idx] = val;
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  task automatic load_triangle(coord_t v[6]);
    for (int i = 0; i < 6; i++) write_reg(reg_idx_e'(i), v[i]);
  endtask

  task automatic drain_pipe();
    int unsigned waited;
    waited = 0;
    while (warp_q.size() != 0) @(posedge clk_i);
    while (waited < Latency + 4) begin
      @(posedge clk_i);
      waited++;
    end
  endtask

  task automatic send_point(warp_in_t p);
    @(negedge clk_i);
    s_axis_tdata = p;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    n_sent++;
  endtask

  // burst gaps between items
  task automatic maybe_gap(inout int burst);
    if (burst > 0) begin
      burst--;
      return;
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    repeat ($urandom_range(1, 6)) @(negedge clk_i);
    burst = $urandom_range(0, 40);
  endtask

  function automatic coord_t rnd_coord();
    case ($urandom_range(0, 7))
      0: return coord_t'($urandom_range(0, 1) ? 16'h7fff : 16'h8000);
      1, 2: return coord_t'($signed($urandom_range(0, 255)) - 128);
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic warp_in_t rnd_point();
    warp_in_t p;
    p = {$urandom, $urandom, $urandom, $urandom};
    if ($urandom_range(0, 2) != 0) begin
      p.px = rnd_coord(); p.py = rnd_coord();
      p.dv1x = rnd_coord(); p.dv1y = rnd_coord();
      p.dv2x = rnd_coord(); p.dv2y = rnd_coord();
      p.dv3x = rnd_coord(); p.dv3y = rnd_coord();
    end
    return p;
  endfunction

  // accepted inputs feed the predictor
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      warp_q.push_back(warp_point(warp_in_t'(s_axis_tdata)));
  end

  // result checker
  always @(posedge clk_i) begin
    warp_out_t want, got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.ox = m_axis_tdata[CW-1:0];
      got.oy = m_axis_tdata[2*CW-1:CW];
      got.degen = m_axis_tuser;
      n_got++;
      if (warp_q.size() == 0) begin
        $error("result with nothing expected: out_x %0d out_y %0d", got.ox, got.oy);
        n_errors++;
      end else begin
        want = warp_q.pop_front();
        if (want.degen) n_degen++;
        if (!want.degen && (want.ox == 16'sh7fff || want.ox == 16'sh8000)) n_sat++;
        if (got.ox !== want.ox) begin
          $error("out_x expected %0d actual %0d", want.ox, got.ox);
          n_errors++;
        end
        if (got.oy !== want.oy) begin
          $error("out_y expected %0d actual %0d", want.oy, got.oy);
          n_errors++;
        end
        if (got.degen !== want.degen) begin
          $error("degenerate expected %0b actual %0b", want.degen, got.degen);
          n_errors++;
        end
      end
    end
  end

  // receiver stall pattern plus one long hold-off on request
  initial begin
    int unsigned mode;
    bit held;
    held = 1'b0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_req && !held) begin
        m_axis_tready = 1'b0;
        repeat (3 * Latency) @(negedge clk_i);
        held = 1'b1;
      end
      mode = $urandom_range(0, 9);
      if (mode < 3) m_axis_tready = 1'b1;
      else if (mode < 5) m_axis_tready = 1'b0;
      else m_axis_tready = $urandom_range(0, 2) != 0;
    end
  end

  initial begin
    dir_row_t rows[$];
    dir_row_t row;
    coord_t tri_set[6];
    int burst;
    warp_in_t p;
    n_errors = 0; n_sent = 0; n_got = 0; n_degen = 0; n_sat = 0;
    hold_off_req = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    foreach (src_tri[i]) src_tri[i] = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // after reset the source triangle is all zero: degenerate
    row.pt = '1; row.fixed = 1'b1; row.res = '{ox: '0, oy: '0, degen: 1'b1};
    rows.push_back(row);
    row.pt = '0; rows.push_back(row);
    foreach (rows[i]) begin
      send_point(rows[i].pt);
      if (rows[i].fixed && warp_point(rows[i].pt) != rows[i].res) begin
        $error("reset row %0d: typed result differs from prediction", i);
        n_errors++;
      end
    end
    @(negedge clk_i) s_axis_tvalid = 1'b0;
    drain_pipe();
    rows.delete();

    // right triangle with legs of 16 at the origin
    tri_set = '{16'sd0, 16'sd0, 16'sd16, 16'sd0, 16'sd0, 16'sd16};
    load_triangle(tri_set);
    row.fixed = 1'b0;
    // point at each source vertex picks that target vertex
    row.pt = '{dv3y: 16'sd300, dv3x: -16'sd300, dv2y: 16'sd200, dv2x: -16'sd200,
               dv1y: 16'sd100, dv1x: -16'sd100, py: 16'sd0, px: 16'sd0};
    row.fixed = 1'b1; row.res = '{ox: -16'sd100, oy: 16'sd100, degen: 1'b0};
    rows.push_back(row);
    row.pt.px = 16'sd16; row.res = '{ox: -16'sd200, oy: 16'sd200, degen: 1'b0};
    rows.push_back(row);
    row.pt.px = 16'sd0; row.pt.py = 16'sd16;
    row.res = '{ox: -16'sd300, oy: 16'sd300, degen: 1'b0};
    rows.push_back(row);
    // far points and extreme targets saturate both ways
    row.fixed = 1'b0;
    row.pt = '{dv3y: 16'sh7fff, dv3x: 16'sh8000, dv2y: 16'sh8000, dv2x: 16'sh7fff,
               dv1y: 16'sh7fff, dv1x: 16'sh8000, py: 16'sh7fff, px: 16'sh8000};
    rows.push_back(row);
    row.pt.px = 16'sh7fff; row.pt.py = 16'sh8000; rows.push_back(row);
    row.pt = '1; rows.push_back(row);
    row.pt = {4{32'h8000_7fff}}; rows.push_back(row);
    row.pt = {4{32'h7fff_8000}}; rows.push_back(row);
    // rounding near ties
    row.pt = '{dv3y: 16'sd1, dv3x: -16'sd1, dv2y: 16'sd0, dv2x: 16'sd0,
               dv1y: 16'sd0, dv1x: 16'sd0, py: 16'sd8, px: 16'sd0};
    rows.push_back(row);
    row.pt.py = -16'sd8; rows.push_back(row);
    foreach (rows[i]) begin
      send_point(rows[i].pt);
      if (rows[i].fixed && warp_point(rows[i].pt) != rows[i].res) begin
        $error("directed row %0d: typed result differs from prediction", i);
        n_errors++;
      end
    end
    @(negedge clk_i) s_axis_tvalid = 1'b0;
    drain_pipe();

    // extreme source triangle, widest determinant
    tri_set = '{16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff};
    load_triangle(tri_set);
    for (int i = 0; i < 6; i++) send_point(rnd_point());
    @(negedge clk_i) s_axis_tvalid = 1'b0;
    drain_pipe();

    // random phases with new triangles, one phase under a long receiver hold-off
    burst = 0;
    for (int ph = 0; ph < 8; ph++) begin
      for (int i = 0; i < 6; i++) tri_set[i] = rnd_coord();
      // collinear source in one phase
      if (ph == 3) begin
        tri_set[2] = tri_set[0] + 16'sd32; tri_set[3] = tri_set[1] + 16'sd32;
        tri_set[4] = tri_set[0] - 16'sd16; tri_set[5] = tri_set[1] - 16'sd16;
      end
      load_triangle(tri_set);
      if (ph == 2) hold_off_req = 1'b1;
      for (int i = 0; i < NumRandom / 8; i++) begin
        p = rnd_point();
        send_point(p);
        maybe_gap(burst);
      end
      @(negedge clk_i) s_axis_tvalid = 1'b0;
      drain_pipe();
    end

    $display("sent %0d points, checked %0d results", n_sent, n_got);
    $display("degenerate triangles %0d, saturated x results %0d", n_degen, n_sat);
    if (n_errors == 0 && warp_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
`default_nettype wire
